@@ rtl/ced_pkg.sv @@
// ----------------------------------------------------------------------------
// ced_pkg
// Shared types, character codes and helper functions for the escape decoder.
// ----------------------------------------------------------------------------
package ced_pkg;

    localparam int unsigned ValueWidth = 63;
    localparam int unsigned QueueDepth = 4;
    localparam int unsigned QueuePtrWidth = $clog2(QueueDepth);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_A      = 8'h61;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF     = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] BYTE_SAT  = 8'hFF;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_ESC    = 3'd1,
        MODE_XPEND  = 3'd2,
        MODE_HEX    = 3'd3,
        MODE_OCT1   = 3'd4,
        MODE_OCT2   = 3'd5
    } mode_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       finish;
    } req_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic       last;
    } rsp_t;

    typedef struct packed {
        logic two;
        rsp_t r0;
        rsp_t r1;
    } entry_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] digit;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.digit = 4'd0;
        if (c >= CH_0 && c <= CH_9)
        begin
            h.digit = 4'(c - CH_0);
        end
        else if (c >= CH_LA && c <= CH_LF)
        begin
            h.digit = 4'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UF)
        begin
            h.digit = 4'(c - CH_UA + 8'd10);
        end
        else
        begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_oct(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_7);
    endfunction

endpackage

@@ rtl/ced_front.sv @@
// ----------------------------------------------------------------------------
// ced_front
// Accepts characters, runs the escape state machine, queues up to two bytes.
// ----------------------------------------------------------------------------
module ced_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ced_pkg::req_t   req,
    input  logic            q_full,
    output logic            push,
    output ced_pkg::entry_t push_entry
);

    ced_pkg::mode_t                   mode_reg, mode_next;
    logic [ced_pkg::ValueWidth-1:0]   value_reg, value_next;
    logic                             sat_reg, sat_next;
    logic                             accept;
    logic                             emit;
    logic                             pend;
    logic [7:0]                       pend_byte;
    ced_pkg::hex_t                    hx;
    logic [7:0]                       c;

    assign req_ready = !q_full;
    assign accept    = req_valid && req_ready;
    assign push      = accept && emit;
    assign c         = req.char_in;
    assign hx        = ced_pkg::hex_digit(c);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ced_pkg::MODE_NORMAL;
            value_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    always_comb
    begin
        pend      = 1'b1;
        pend_byte = value_reg[7:0];
        unique case (mode_reg)
            ced_pkg::MODE_ESC:   pend_byte = ced_pkg::CH_BSLASH;
            ced_pkg::MODE_XPEND: pend_byte = ced_pkg::CH_X;
            ced_pkg::MODE_HEX:   pend_byte = sat_reg ? ced_pkg::BYTE_SAT : value_reg[7:0];
            ced_pkg::MODE_OCT1,
            ced_pkg::MODE_OCT2:  pend_byte = value_reg[7:0];
            default:             pend = 1'b0;
        endcase
    end

    always_comb
    begin
        mode_next  = mode_reg;
        value_next = value_reg;
        sat_next   = sat_reg;
        emit       = 1'b0;
        push_entry = '0;

        if (req.finish)
        begin
            emit                   = 1'b1;
            push_entry.r0.byte_out = pend ? pend_byte : 8'd0;
            push_entry.r0.has_byte = pend;
            push_entry.r0.last     = 1'b1;
            mode_next              = ced_pkg::MODE_NORMAL;
        end
        else
        begin
            // A flush emits the pending byte first, then the character as text unless it is a backslash.
            logic flush;
            flush = 1'b0;
            unique case (mode_reg)
                ced_pkg::MODE_ESC:
                begin
                    mode_next = ced_pkg::MODE_NORMAL;
                    emit      = 1'b1;
                    push_entry.r0.has_byte = 1'b1;
                    unique case (c)
                        ced_pkg::CH_BSLASH: push_entry.r0.byte_out = 8'h5C;
                        ced_pkg::CH_T:      push_entry.r0.byte_out = 8'h09;
                        ced_pkg::CH_A:      push_entry.r0.byte_out = 8'h07;
                        ced_pkg::CH_N:      push_entry.r0.byte_out = 8'h0A;
                        ced_pkg::CH_F:      push_entry.r0.byte_out = 8'h0C;
                        ced_pkg::CH_R:      push_entry.r0.byte_out = 8'h0D;
                        default:            push_entry.r0.byte_out = c;
                    endcase
                    if (c == ced_pkg::CH_X)
                    begin
                        emit      = 1'b0;
                        mode_next = ced_pkg::MODE_XPEND;
                    end
                    else if (ced_pkg::is_oct(c))
                    begin
                        emit       = 1'b0;
                        mode_next  = ced_pkg::MODE_OCT1;
                        value_next = ced_pkg::ValueWidth'(c - ced_pkg::CH_0);
                    end
                end
                ced_pkg::MODE_XPEND:
                begin
                    if (hx.valid)
                    begin
                        value_next = ced_pkg::ValueWidth'(hx.digit);
                        sat_next   = 1'b0;
                        mode_next  = ced_pkg::MODE_HEX;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                ced_pkg::MODE_HEX:
                begin
                    if (hx.valid)
                    begin
                        if (sat_reg || (value_reg[62:59] != 4'd0))
                        begin
                            sat_next = 1'b1;
                        end
                        else
                        begin
                            value_next = {value_reg[58:0], hx.digit};
                        end
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                ced_pkg::MODE_OCT1:
                begin
                    if (ced_pkg::is_oct(c))
                    begin
                        value_next = {value_reg[59:0], c[2:0]};
                        mode_next  = ced_pkg::MODE_OCT2;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                ced_pkg::MODE_OCT2:
                begin
                    if (ced_pkg::is_oct(c))
                    begin
                        value_next = {value_reg[59:0], c[2:0]};
                        mode_next  = ced_pkg::MODE_NORMAL;
                        emit       = 1'b1;
                        push_entry.r0.byte_out = {value_reg[4:0], c[2:0]};
                        push_entry.r0.has_byte = 1'b1;
                    end
                    else
                    begin
                        flush = 1'b1;
                    end
                end
                default:
                begin
                    if (c == ced_pkg::CH_BSLASH)
                    begin
                        mode_next = ced_pkg::MODE_ESC;
                    end
                    else
                    begin
                        mode_next = ced_pkg::MODE_NORMAL;
                        emit      = 1'b1;
                        push_entry.r0.byte_out = c;
                        push_entry.r0.has_byte = 1'b1;
                    end
                end
            endcase

            if (flush)
            begin
                emit                   = 1'b1;
                push_entry.r0.byte_out = pend_byte;
                push_entry.r0.has_byte = 1'b1;
                if (c == ced_pkg::CH_BSLASH)
                begin
                    mode_next = ced_pkg::MODE_ESC;
                end
                else
                begin
                    mode_next              = ced_pkg::MODE_NORMAL;
                    push_entry.two         = 1'b1;
                    push_entry.r1.byte_out = c;
                    push_entry.r1.has_byte = 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/ced_queue.sv @@
// ----------------------------------------------------------------------------
// ced_queue
// Small register queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
module ced_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ced_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output ced_pkg::entry_t head
);

    localparam int unsigned CntWidth = ced_pkg::QueuePtrWidth + 1;

    ced_pkg::entry_t                   mem_reg [ced_pkg::QueueDepth];
    logic [ced_pkg::QueuePtrWidth-1:0] wr_reg, rd_reg;
    logic [CntWidth-1:0]               cnt_reg;
    logic                              do_push, do_pop;

    assign full    = (cnt_reg == CntWidth'(ced_pkg::QueueDepth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/ced_back.sv @@
// ----------------------------------------------------------------------------
// ced_back
// Unpacks queued entries into single result beats behind an output register.
// ----------------------------------------------------------------------------
module ced_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  ced_pkg::entry_t head,
    output logic            pop,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ced_pkg::rsp_t   rsp
);

    logic          out_valid_reg;
    ced_pkg::rsp_t out_reg;
    logic          spare_valid_reg;
    ced_pkg::rsp_t spare_reg;
    logic          slot_free;

    assign slot_free = !out_valid_reg || rsp_ready;
    assign pop       = slot_free && !spare_valid_reg && !q_empty;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg   <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            if (spare_valid_reg)
            begin
                out_valid_reg   <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg   <= !q_empty;
                spare_valid_reg <= !q_empty && head.two;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free)
        begin
            if (spare_valid_reg)
            begin
                out_reg <= spare_reg;
            end
            else
            begin
                out_reg   <= head.r0;
                spare_reg <= head.r1;
            end
        end
    end

endmodule

@@ rtl/c_escape_sequence_decoder.sv @@
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder
// C backslash escape decoder: one character beat in, zero to two bytes out.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   ced_pkg::req_t (char_in, finish)
//   rsp      out  rsp_valid / rsp_ready   ced_pkg::rsp_t (byte_out, has_byte, last)
//
// One req beat per cycle unless the queue is full; the escape state machine updates
// in the cycle of acceptance. Results leave one per cycle while rsp_ready is high,
// from an output register loaded at the queue read. A character that flushes a
// pending escape yields two beats; output bandwidth bounds the rate of such streams.
// Reset clears the decode state, the four-entry queue and the output stage.
// Either side may stall; req_ready drops only while the queue is full.
// ----------------------------------------------------------------------------
module c_escape_sequence_decoder (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ced_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ced_pkg::rsp_t rsp
);

    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    ced_pkg::entry_t push_entry;
    ced_pkg::entry_t head;

    ced_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    ced_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .empty      (q_empty),
        .head       (head)
    );

    ced_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
